// ===== rtl/hsv_hue_saturation_value_adjust_assert.svh =====
// assertion macros shared by the hsv adjust rtl
// no dependencies; included by modules that carry checks
`ifndef HSV_HUE_SATURATION_VALUE_ADJUST_ASSERT_SVH
`define HSV_HUE_SATURATION_VALUE_ADJUST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsv check failed");

// next-cycle implication, disabled during reset
`define HSV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsv check failed");

`endif

// ===== rtl/hsv_pkg.sv =====
// shared types, constants and helper functions for the hsv adjust block
// no dependencies
package hsv_pkg;

    // fixed point scale
    localparam int ONE_FX   = 4096;
    localparam int HUE_60   = 960;
    localparam int HUE_FULL = 5760;

    // divider: quotient bits per operand
    localparam int DIV_STEPS = 13;

    // request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_HUE_SHIFT = 2'd0;
    localparam logic [1:0] CFG_SAT_DELTA = 2'd1;
    localparam logic [1:0] CFG_VAL_DELTA = 2'd2;

    // dominant channel codes
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       edit;
    } t_pix;

    typedef struct packed {
        logic signed [13:0] hue_shift;
        logic signed [13:0] sat_delta;
        logic signed [13:0] val_delta;
    } t_cfg;

    // classification carried alongside the division
    typedef struct packed {
        t_pix        pix;
        logic [12:0] val;
        logic [1:0]  sect;
        logic        neg;
        logic        mx_zero;
        logic        d_zero;
    } t_fctx;

    typedef struct packed {
        logic [20:0] num_s;
        logic [8:0]  den_s;
        logic [20:0] num_h;
        logic [8:0]  den_h;
        t_fctx       ctx;
    } t_div_op;

    typedef struct packed {
        logic [8:0]  rem_s;
        logic [8:0]  rem_h;
        logic [12:0] lo_s;
        logic [12:0] lo_h;
        logic [8:0]  den_s;
        logic [8:0]  den_h;
        logic [12:0] q_s;
        logic [12:0] q_h;
        t_fctx       ctx;
    } t_div_stg;

    typedef struct packed {
        logic [12:0] q_s;
        logic [12:0] q_h;
        t_fctx       ctx;
    } t_div_res;

    // queue entry: hsv of one pixel plus the original pixel
    typedef struct packed {
        t_pix               pix;
        logic signed [13:0] hue;
        logic [12:0]        sat;
        logic [12:0]        val;
    } t_qent;

    typedef logic [12:0] t_val_lut [256];

    // value = round(mx * 4096 / 255), built at elaboration
    function automatic t_val_lut gen_val_lut();
        t_val_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = 13'((i * 8192 + 255) / 510);
        end
        return lut;
    endfunction

    localparam t_val_lut VAL_LUT = gen_val_lut();

    // channel sum * 255 plus half scale, upper bits above 2^30
    function automatic logic [11:0] scale255(input logic [33:0] c);
        logic [41:0] y;
        y = ({8'd0, c} << 8) - {8'd0, c} + 42'd8053063680;
        return y[41:30];
    endfunction

    // floor(t / 15) by reciprocal, exact for t below 3840
    function automatic logic [7:0] div15(input logic [11:0] t);
        logic [27:0] p;
        p = {16'd0, t} * 28'd34953;
        return p[26:19];
    endfunction

endpackage

// ===== rtl/hsv_div.sv =====
// pipelined restoring divider, one quotient bit per stage, two divisions in lockstep
// depends on hsv_pkg
module hsv_div import hsv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_op  i_op,
    output logic     o_valid,
    output t_div_res o_res
);

    t_div_stg             r_stg [DIV_STEPS+1];
    t_div_stg             n_stg [DIV_STEPS+1];
    logic [DIV_STEPS:0]   r_vld;

    // one shift and conditional subtract for both operands
    function automatic t_div_stg div_step(input t_div_stg s);
        t_div_stg   r;
        logic [9:0] t_s;
        logic [9:0] t_h;
        r    = s;
        t_s  = {s.rem_s, s.lo_s[12]};
        t_h  = {s.rem_h, s.lo_h[12]};
        r.lo_s = {s.lo_s[11:0], 1'b0};
        r.lo_h = {s.lo_h[11:0], 1'b0};
        if (t_s >= {1'b0, s.den_s}) begin
            r.rem_s = 9'(t_s - {1'b0, s.den_s});
            r.q_s   = {s.q_s[11:0], 1'b1};
        end else begin
            r.rem_s = t_s[8:0];
            r.q_s   = {s.q_s[11:0], 1'b0};
        end
        if (t_h >= {1'b0, s.den_h}) begin
            r.rem_h = 9'(t_h - {1'b0, s.den_h});
            r.q_h   = {s.q_h[11:0], 1'b1};
        end else begin
            r.rem_h = t_h[8:0];
            r.q_h   = {s.q_h[11:0], 1'b0};
        end
        return r;
    endfunction

    // load stage and step stages
    always_comb begin
        n_stg[0].rem_s = {1'b0, i_op.num_s[20:13]};
        n_stg[0].rem_h = {1'b0, i_op.num_h[20:13]};
        n_stg[0].lo_s  = i_op.num_s[12:0];
        n_stg[0].lo_h  = i_op.num_h[12:0];
        n_stg[0].den_s = i_op.den_s;
        n_stg[0].den_h = i_op.den_h;
        n_stg[0].q_s   = '0;
        n_stg[0].q_h   = '0;
        n_stg[0].ctx   = i_op.ctx;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            n_stg[j] = div_step(r_stg[j-1]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_valid   = r_vld[DIV_STEPS];
    assign o_res.q_s = r_stg[DIV_STEPS].q_s;
    assign o_res.q_h = r_stg[DIV_STEPS].q_h;
    assign o_res.ctx = r_stg[DIV_STEPS].ctx;

endmodule

// ===== rtl/hsv_front.sv =====
// front end: takes pixels, finds max, min and sector, divides for s and hue
// depends on hsv_pkg and hsv_div
module hsv_front import hsv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_pix  i_pix,
    output logic  o_valid,
    output t_qent o_ent
);

    logic               r_v0;
    t_pix               r_pix;
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         d;
    logic signed [8:0]  num;
    logic [8:0]         num_neg;
    logic [7:0]         mag;
    logic [1:0]         sect;
    t_div_op            op;
    t_div_res           res;
    logic signed [13:0] hue_base;
    logic signed [13:0] q_h;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pix;
        end
    end

    // max, min and dominant channel, ties to red then green
    always_comb begin
        mx = r_pix.red;
        if (r_pix.green > mx) mx = r_pix.green;
        if (r_pix.blue > mx) mx = r_pix.blue;
        mn = r_pix.red;
        if (r_pix.green < mn) mn = r_pix.green;
        if (r_pix.blue < mn) mn = r_pix.blue;
        d = mx - mn;
        if (mx == r_pix.red) begin
            sect = SECT_RED;
            num  = $signed({1'b0, r_pix.green}) - $signed({1'b0, r_pix.blue});
        end else if (mx == r_pix.green) begin
            sect = SECT_GREEN;
            num  = $signed({1'b0, r_pix.blue}) - $signed({1'b0, r_pix.red});
        end else begin
            sect = SECT_BLUE;
            num  = $signed({1'b0, r_pix.red}) - $signed({1'b0, r_pix.green});
        end
        num_neg = 9'(-num);
        mag     = num[8] ? num_neg[7:0] : num[7:0];
    end

    // divider operands with rounding terms folded in
    always_comb begin
        op.num_s       = {d, 13'd0} + {13'd0, mx};
        op.den_s       = {mx, 1'b0};
        op.num_h       = ({13'd0, mag} * 21'd1920) + {13'd0, d};
        op.den_h       = {d, 1'b0};
        op.ctx.pix     = r_pix;
        op.ctx.val     = VAL_LUT[mx];
        op.ctx.sect    = sect;
        op.ctx.neg     = num[8];
        op.ctx.mx_zero = (mx == 8'd0);
        op.ctx.d_zero  = (d == 8'd0);
    end

    hsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v0),
        .i_op    (op),
        .o_valid (o_valid),
        .o_res   (res)
    );

    // assemble hue from sector base and signed in-sector part
    always_comb begin
        case (res.ctx.sect)
            SECT_RED:   hue_base = 14'sd0;
            SECT_GREEN: hue_base = 14'sd1920;
            SECT_BLUE:  hue_base = 14'sd3840;
            default:    hue_base = 14'sd0;
        endcase
        q_h       = $signed({1'b0, res.q_h});
        o_ent.pix = res.ctx.pix;
        o_ent.val = res.ctx.val;
        o_ent.sat = res.ctx.mx_zero ? 13'd0 : res.q_s;
        if (res.ctx.d_zero) begin
            o_ent.hue = 14'sd0;
        end else if (res.ctx.neg) begin
            o_ent.hue = hue_base - q_h;
        end else begin
            o_ent.hue = hue_base + q_h;
        end
    end

endmodule

// ===== rtl/hsv_fifo.sv =====
// short request queue decoupling the front end from the back end
// depends on hsv_pkg and the assertion macro header
`include "hsv_hue_saturation_value_adjust_assert.svh"
module hsv_fifo import hsv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_qent i_data,
    input  logic  i_rd,
    output t_qent o_data,
    output logic  o_full,
    output logic  o_empty
);

    t_qent           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    `HSV_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_wr, !o_full || i_rd)
    `HSV_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_rd, !o_empty)
    `HSV_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, i_wr && !i_rd, r_cnt == $past(r_cnt) + 3'd1)
    `HSV_ASSERT_IMP(a_flags, i_clk, i_rst_n, 1'b1, !(o_full && o_empty))

endmodule

// ===== rtl/hsv_back.sv =====
// back end: hue shift and wrap, s and v clamp, hsv to rgb, output register
// depends on hsv_pkg
module hsv_back import hsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_qent       i_ent,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);

    logic en;

    // stage 1 signals
    logic signed [15:0] hsum;
    logic [15:0]        hx;
    logic [15:0]        wrap_sub;
    logic signed [14:0] ssum;
    logic signed [14:0] vsum;
    logic [12:0]        sat_c;
    logic [12:0]        val_c;
    logic               r_v1;
    logic [12:0]        r_h1;
    logic [12:0]        r_s1;
    logic [12:0]        r_val1;
    t_pix               r_pix1;

    // stage 2 signals
    logic [2:0]         sec;
    logic [12:0]        sec_sub;
    logic [9:0]         frac;
    logic [25:0]        prod;
    logic               r_v2;
    logic [2:0]         r_sec2;
    logic [9:0]         r_k2;
    logic [24:0]        r_vs2;
    logic [12:0]        r_val2;
    t_pix               r_pix2;

    // stage 3 signals
    logic [33:0]        cf;
    logic               r_v3;
    logic [33:0]        r_cf3;
    logic [33:0]        r_xf3;
    logic [33:0]        r_mf3;
    logic [2:0]         r_sec3;
    t_pix               r_pix3;

    // stage 4 signals
    logic [33:0]        rc;
    logic [33:0]        gc;
    logic [33:0]        bc;
    logic               r_v4;
    logic [11:0]        r_rt4;
    logic [11:0]        r_gt4;
    logic [11:0]        r_bt4;
    t_pix               r_pix4;

    // output register
    logic               r_vo;
    logic [31:0]        r_data;

    assign en    = !r_vo || i_ready;
    assign o_pop = en && i_valid;

    // hue wrap into one turn, clamp s and v
    always_comb begin
        hsum     = 16'(i_ent.hue) + 16'(i_cfg.hue_shift);
        hx       = 16'(hsum + 16'sd17280);
        wrap_sub = '0;
        for (int j = 1; j <= 5; j++) begin
            if (hx >= 16'(j * HUE_FULL)) wrap_sub = 16'(j * HUE_FULL);
        end
        ssum = $signed({2'b00, i_ent.sat}) + 15'(i_cfg.sat_delta);
        vsum = $signed({2'b00, i_ent.val}) + 15'(i_cfg.val_delta);
        if (ssum < 15'sd0) begin
            sat_c = '0;
        end else if (ssum > 15'sd4096) begin
            sat_c = 13'd4096;
        end else begin
            sat_c = ssum[12:0];
        end
        if (vsum < 15'sd0) begin
            val_c = '0;
        end else if (vsum > 15'sd4096) begin
            val_c = 13'd4096;
        end else begin
            val_c = vsum[12:0];
        end
    end

    // sector, distance into sector, v times s
    always_comb begin
        sec     = '0;
        sec_sub = '0;
        for (int j = 1; j <= 5; j++) begin
            if (r_h1 >= 13'(j * HUE_60)) begin
                sec     = 3'(j);
                sec_sub = 13'(j * HUE_60);
            end
        end
        frac = 10'(r_h1 - sec_sub);
        prod = {13'd0, r_val1} * {13'd0, r_s1};
    end

    assign cf = {9'd0, r_vs2} * 34'd960;

    // per-channel sums by sector
    always_comb begin
        rc = r_mf3;
        gc = r_mf3;
        bc = r_mf3;
        case (r_sec3)
            3'd0: begin rc = r_mf3 + r_cf3; gc = r_mf3 + r_xf3; end
            3'd1: begin rc = r_mf3 + r_xf3; gc = r_mf3 + r_cf3; end
            3'd2: begin gc = r_mf3 + r_cf3; bc = r_mf3 + r_xf3; end
            3'd3: begin gc = r_mf3 + r_xf3; bc = r_mf3 + r_cf3; end
            3'd4: begin rc = r_mf3 + r_xf3; bc = r_mf3 + r_cf3; end
            default: begin rc = r_mf3 + r_cf3; bc = r_mf3 + r_xf3; end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vo <= r_v4;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h1   <= 13'(hx - wrap_sub);
            r_s1   <= sat_c;
            r_val1 <= val_c;
            r_pix1 <= i_ent.pix;

            r_sec2 <= sec;
            r_k2   <= sec[0] ? 10'(10'd960 - frac) : frac;
            r_vs2  <= prod[24:0];
            r_val2 <= r_val1;
            r_pix2 <= r_pix1;

            r_cf3  <= cf;
            r_xf3  <= {9'd0, r_vs2} * {24'd0, r_k2};
            r_mf3  <= ({21'd0, r_val2} * 34'd3932160) - cf;
            r_sec3 <= r_sec2;
            r_pix3 <= r_pix2;

            r_rt4  <= scale255(rc);
            r_gt4  <= scale255(gc);
            r_bt4  <= scale255(bc);
            r_pix4 <= r_pix3;

            if (r_pix4.edit) begin
                r_data <= {r_pix4.alpha, div15(r_bt4), div15(r_gt4), div15(r_rt4)};
            end else begin
                r_data <= {r_pix4.alpha, r_pix4.blue, r_pix4.green, r_pix4.red};
            end
        end
    end

    assign o_valid = r_vo;
    assign o_data  = r_data;

endmodule

// ===== rtl/hsv_hue_saturation_value_adjust.sv =====
// HSV hue/saturation/value adjust for an RGBA pixel stream, one pixel per clock
// sustained while the output accepts data. A pixel enters and is registered. It
// then passes a pipelined divider with a load stage and 13 quotient-bit stages
// that forms saturation and hue, and lands in a 4-entry queue. The back end takes
// one entry per clock while the output is not stalled, through four arithmetic
// stages and an output register. The divider depth is the largest part of the
// latency. The queue lets the front keep taking pixels while the output is
// briefly stalled. Configuration is written through its own channel, always
// ready, and should be changed only while the block is empty.
// depends on hsv_pkg, hsv_front, hsv_div, hsv_fifo, hsv_back
module hsv_hue_saturation_value_adjust import hsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  logic        i_s_tuser,   // edit_enable
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // red_out, green_out, blue_out, alpha_out
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_pix  in_pix;
    logic  front_en;
    logic  front_valid;
    t_qent front_ent;
    t_qent q_head;
    logic  q_full;
    logic  q_empty;
    logic  q_wr;
    logic  q_rd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HUE_SHIFT: r_cfg.hue_shift <= i_cfg_data;
                CFG_SAT_DELTA: r_cfg.sat_delta <= i_cfg_data;
                CFG_VAL_DELTA: r_cfg.val_delta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // unpack input request
    always_comb begin
        in_pix.red   = i_s_tdata[7:0];
        in_pix.green = i_s_tdata[15:8];
        in_pix.blue  = i_s_tdata[23:16];
        in_pix.alpha = i_s_tdata[31:24];
        in_pix.edit  = i_s_tuser;
    end

    // front advances whenever the queue has room
    assign front_en   = !q_full;
    assign o_s_tready = front_en;
    assign q_wr       = front_valid && front_en;

    hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (i_s_tvalid),
        .i_pix   (in_pix),
        .o_valid (front_valid),
        .o_ent   (front_ent)
    );

    hsv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (front_ent),
        .i_rd    (q_rd),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (!q_empty),
        .i_ent   (q_head),
        .o_pop   (q_rd),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule
